// ===== rtl/ppu_pkg.sv =====
package ppu_pkg;

   localparam int DIM_W      = 13;
   localparam int MAX_DIM    = 4096;
   localparam int DIM_TOP    = (1 << DIM_W) - 1;
   localparam int DIM_CAP    = (MAX_DIM > DIM_TOP) ? DIM_TOP : MAX_DIM;
   localparam logic [DIM_W-1:0] DIM_CAP_C = DIM_W'(DIM_CAP);

   localparam int OFFS_W     = 24;
   localparam int COLOR_W    = 24;
   localparam int RGBA_W     = 32;
   localparam int IDX_W      = 8;
   localparam int LIMIT_W    = 9;
   localparam int BPP_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BPP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLORS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_DOWN  = 3'd5;

   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_DATA    = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Effective index width, as a code.
   localparam logic [1:0] BPP_1 = 2'd0;
   localparam logic [1:0] BPP_2 = 2'd1;
   localparam logic [1:0] BPP_4 = 2'd2;
   localparam logic [1:0] BPP_8 = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         palette_slot;
      logic [COLOR_W-1:0] palette_color;
      logic [7:0]         data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [OFFS_W-1:0] pixel_offset;
      logic [RGBA_W-1:0] rgba;
      logic              status;
      logic              last_of_byte;
      logic              image_done;
   } rsp_payload_type;

   typedef struct packed {
      logic               changed;
      logic [1:0]         bpp;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [LIMIT_W-1:0] limit;
      logic               mirror_x;
      logic               top_down;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [OFFS_W-1:0] offset;
      logic              status;
      logic              last;
      logic              done;
   } pix_type;

   typedef struct packed {
      logic               en;
      logic [7:0]         slot;
      logic [COLOR_W-1:0] color;
   } pal_wr_type;

endpackage

// ===== rtl/ppu_csr.sv =====
module ppu_csr
   import ppu_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   localparam logic [LIMIT_W-1:0] DEPTH_C = LIMIT_W'(PALETTE_DEPTH);

   logic [BPP_W-1:0]   bpp_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [LIMIT_W-1:0] colors_ff;
   logic               mirror_ff;
   logic               top_down_ff;

   logic [1:0]         bpp_code;
   logic [LIMIT_W-1:0] pow;
   logic [LIMIT_W-1:0] lim_a;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_CAP_C) begin
         r = DIM_CAP_C;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff      <= BPP_W'(8);
         width_ff    <= DIM_W'(1);
         height_ff   <= DIM_W'(1);
         colors_ff   <= '0;
         mirror_ff   <= 1'b0;
         top_down_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BPP:      bpp_ff      <= csr_wdata[BPP_W-1:0];
            CSR_WIDTH:    width_ff    <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:   height_ff   <= csr_wdata[DIM_W-1:0];
            CSR_COLORS:   colors_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_MIRROR_X: mirror_ff   <= csr_wdata[0];
            CSR_TOP_DOWN: top_down_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (bpp_ff)
         BPP_W'(1): begin
            bpp_code = BPP_1;
            pow      = LIMIT_W'(2);
         end
         BPP_W'(2): begin
            bpp_code = BPP_2;
            pow      = LIMIT_W'(4);
         end
         BPP_W'(4): begin
            bpp_code = BPP_4;
            pow      = LIMIT_W'(16);
         end
         default: begin
            bpp_code = BPP_8;
            pow      = LIMIT_W'(256);
         end
      endcase
      lim_a = ((colors_ff != '0) && (colors_ff < pow)) ? colors_ff : pow;
   end

   assign cfg.changed  = csr_we;
   assign cfg.bpp      = bpp_code;
   assign cfg.width    = clamp_dim(width_ff);
   assign cfg.height   = clamp_dim(height_ff);
   assign cfg.limit    = (lim_a > DEPTH_C) ? DEPTH_C : lim_a;
   assign cfg.mirror_x = mirror_ff;
   assign cfg.top_down = top_down_ff;

endmodule

// ===== rtl/ppu_unpack.sv =====
module ppu_unpack
   import ppu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       load,
   input  logic [7:0] load_byte,
   input  logic       adv,
   output logic       take_ok,
   output logic       stuck,
   output pix_type    pix
);

   localparam logic [1:0] FIX_NORM = 2'd0;
   localparam logic [1:0] FIX_BASE = 2'd1;
   localparam logic [1:0] FIX_WRAP = 2'd2;

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        shift_ff, shift_in;
   logic [2:0]        k_ff, k_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  x_ff, x_in;
   logic [OFFS_W-1:0] base_ff, base_in;
   logic [OFFS_W-1:0] wrap_ff, wrap_in;
   logic              ok_ff, ok_in;
   logic [1:0]        fix_ff, fix_in;
   logic              err_ff, err_in;

   logic [IDX_W-1:0]   idx;
   logic [2:0]         last_k;
   logic [7:0]         shift_next;
   logic               bad;
   logic [DIM_W-1:0]   col_inc, row_inc, row_t;
   logic               row_end, wrap;
   logic               issue, byte_last, fin;
   logic [DIM_W-1:0]   h_m1, y, mul_a;
   logic [2*DIM_W-1:0] prod;
   logic [OFFS_W-1:0]  w_ext;

   always_comb begin
      case (cfg.bpp)
         BPP_1: begin
            idx        = {7'b0, shift_ff[7]};
            last_k     = 3'd7;
            shift_next = {shift_ff[6:0], 1'b0};
         end
         BPP_2: begin
            idx        = {6'b0, shift_ff[7:6]};
            last_k     = 3'd3;
            shift_next = {shift_ff[5:0], 2'b0};
         end
         BPP_4: begin
            idx        = {4'b0, shift_ff[7:4]};
            last_k     = 3'd1;
            shift_next = {shift_ff[3:0], 4'b0};
         end
         default: begin
            idx        = shift_ff;
            last_k     = 3'd0;
            shift_next = 8'b0;
         end
      endcase
   end

   assign bad       = {1'b0, idx} >= cfg.limit;
   assign col_inc   = col_ff + DIM_W'(1);
   assign row_inc   = row_ff + DIM_W'(1);
   assign row_end   = col_inc >= cfg.width;
   assign wrap      = row_inc >= cfg.height;
   assign issue     = s1_valid_ff && ok_ff && adv;
   assign byte_last = row_end || (k_ff == last_k);
   assign fin       = issue && (bad || byte_last);
   assign take_ok   = !s1_valid_ff || fin;
   // A byte taken alongside an issuing error pixel is already dropped.
   assign stuck     = err_ff || (issue && bad);

   // One multiplier serves both base products while the position is rebuilt.
   assign h_m1  = cfg.height - DIM_W'(1);
   assign y     = cfg.top_down ? row_ff : (h_m1 - row_ff);
   assign mul_a = (fix_ff == FIX_BASE) ? y : h_m1;
   assign prod  = {{DIM_W{1'b0}}, mul_a} * {{DIM_W{1'b0}}, cfg.width};
   assign w_ext = {{(OFFS_W-DIM_W){1'b0}}, cfg.width};
   assign row_t = (col_ff >= cfg.width) ? row_inc : row_ff;

   assign pix.valid  = issue;
   assign pix.idx    = idx;
   assign pix.offset = base_ff + {{(OFFS_W-DIM_W){1'b0}}, x_ff};
   assign pix.status = bad ? STATUS_RANGE : STATUS_OK;
   assign pix.last   = bad || byte_last;
   assign pix.done   = !bad && row_end && wrap;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      shift_in    = shift_ff;
      k_in        = k_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      x_in        = x_ff;
      base_in     = base_ff;
      wrap_in     = wrap_ff;
      ok_in       = ok_ff;
      fix_in      = fix_ff;
      err_in      = err_ff;

      // After a register write the position is rebuilt before the first pixel.
      if (s1_valid_ff && !ok_ff) begin
         case (fix_ff)
            FIX_NORM: begin
               col_in = (col_ff >= cfg.width) ? '0 : col_ff;
               row_in = (row_t >= cfg.height) ? '0 : row_t;
               fix_in = FIX_BASE;
            end
            FIX_BASE: begin
               base_in = prod[OFFS_W-1:0];
               x_in    = cfg.mirror_x ? (cfg.width - DIM_W'(1) - col_ff) : col_ff;
               fix_in  = FIX_WRAP;
            end
            FIX_WRAP: begin
               wrap_in = prod[OFFS_W-1:0];
               ok_in   = 1'b1;
               fix_in  = FIX_NORM;
            end
            default: begin
               fix_in = FIX_NORM;
            end
         endcase
      end

      if (issue) begin
         if (bad) begin
            err_in = 1'b1;
         end else if (row_end) begin
            col_in = '0;
            x_in   = cfg.mirror_x ? (cfg.width - DIM_W'(1)) : '0;
            if (wrap) begin
               row_in  = '0;
               base_in = cfg.top_down ? '0 : wrap_ff;
            end else begin
               row_in  = row_inc;
               base_in = cfg.top_down ? (base_ff + w_ext) : (base_ff - w_ext);
            end
         end else begin
            col_in = col_inc;
            x_in   = cfg.mirror_x ? (x_ff - DIM_W'(1)) : (x_ff + DIM_W'(1));
         end
      end

      if (fin) begin
         s1_valid_in = 1'b0;
      end else if (issue) begin
         shift_in = shift_next;
         k_in     = k_ff + 3'd1;
      end

      if (load) begin
         s1_valid_in = 1'b1;
         shift_in    = load_byte;
         k_in        = '0;
      end

      if (cfg.changed) begin
         ok_in  = 1'b0;
         fix_in = FIX_NORM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
         ok_ff       <= 1'b0;
         fix_ff      <= FIX_NORM;
         err_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         ok_ff       <= ok_in;
         fix_ff      <= fix_in;
         err_ff      <= err_in;
      end
      shift_ff <= shift_in;
      k_ff     <= k_in;
      x_ff     <= x_in;
      base_ff  <= base_in;
      wrap_ff  <= wrap_in;
   end

endmodule

// ===== rtl/ppu_palette.sv =====
module ppu_palette
   import ppu_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  pal_wr_type      wr,
   input  pix_type         pix,
   input  logic            rsp_ready,
   output logic            adv,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);
   localparam logic [LIMIT_W-1:0] DEPTH_C = LIMIT_W'(PALETTE_DEPTH);

   logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rdata_ff;

   logic              v_ff, v_in;
   logic [OFFS_W-1:0] offset_ff;
   logic              status_ff;
   logic              last_ff;
   logic              done_ff;

   assign adv  = !v_ff || rsp_ready;
   assign v_in = adv ? pix.valid : v_ff;

   // A read and a write in the same cycle return the entry's old contents.
   always_ff @(posedge clock) begin
      if (wr.en && ({1'b0, wr.slot} < DEPTH_C)) begin
         mem[wr.slot[ADDR_W-1:0]] <= wr.color;
      end
      if (pix.valid) begin
         rdata_ff <= mem[pix.idx[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (pix.valid) begin
         offset_ff <= pix.offset;
         status_ff <= pix.status;
         last_ff   <= pix.last;
         done_ff   <= pix.done;
      end
   end

   assign rsp_valid                = v_ff;
   assign rsp_payload.pixel_offset = offset_ff;
   assign rsp_payload.rgba         = (status_ff == STATUS_RANGE) ? '0 :
                                     {rdata_ff, ALPHA_OPAQUE};
   assign rsp_payload.status       = status_ff;
   assign rsp_payload.last_of_byte = last_ff;
   assign rsp_payload.image_done   = done_ff;

endmodule

// ===== rtl/paletted_pixel_unpacker.sv =====
// Paletted pixel unpacker. Each data byte transaction on req_ carries 1, 2, 4 or
// 8 bit palette indices, most significant first; each index comes out on rsp_ as
// one transaction holding its destination offset and RGBA colour from the
// palette RAM, which palette-write transactions load. A data byte gives its pixels,
// up to a row end, one per cycle while rsp_ready lets the output move, set by the
// single read port of the palette RAM; at 8 bpp a byte is taken every cycle under
// the same condition. After reset and any configuration write the first data byte
// waits while the row position and base offsets are rebuilt with a shared
// multiplier. Results are registered at the palette read. Once an index beyond the
// palette limit has been reported, data bytes are taken and dropped until reset.
module paletted_pixel_unpacker
   import ppu_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   pix_type    pix;
   pal_wr_type wr;
   logic       accept;
   logic       take_ok;
   logic       stuck;
   logic       adv;
   logic       load;

   assign req_ready = take_ok;
   assign accept    = req_valid && req_ready;
   assign load      = accept && (req_payload.req_type == REQ_DATA) && !stuck;

   assign wr.en    = accept && (req_payload.req_type == REQ_PALETTE);
   assign wr.slot  = req_payload.palette_slot;
   assign wr.color = req_payload.palette_color;

   ppu_csr #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   ppu_unpack u_unpack (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .load     (load),
      .load_byte(req_payload.data_byte),
      .adv      (adv),
      .take_ok  (take_ok),
      .stuck    (stuck),
      .pix      (pix)
   );

   ppu_palette #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .pix        (pix),
      .rsp_ready  (rsp_ready),
      .adv        (adv),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== tb/paletted_pixel_unpacker_tb.sv =====
module paletted_pixel_unpacker_tb;
   import ppu_pkg::*;

   localparam int PAL_DEPTH     = 256;
   localparam int IDLE_PCT      = 13;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Own copy of the palette, position counters and registers.
   logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
   bit                 pal_valid [PAL_DEPTH];
   int unsigned        col_cnt;
   int unsigned        row_cnt;
   bit                 stuck;
   logic [3:0]         cfg_bpp;
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;
   logic [LIMIT_W-1:0] cfg_colors;
   logic               cfg_mirror;
   logic               cfg_top_down;

   rsp_payload_type expected_pixels [$];
   int              mismatch_count;
   bit              tx_idle_on;
   bit              rx_idle_on;
   bit              hold_go;
   int              hold_left;

   paletted_pixel_unpacker #(
      .PALETTE_DEPTH (PAL_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[paletted_pixel_unpacker] ERROR");
      $finish;
   end

   function automatic int unsigned eff_bits();
      case (cfg_bpp)
         4'd1, 4'd2, 4'd4: return cfg_bpp;
         default: return 8;
      endcase
   endfunction

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic int unsigned pal_limit();
      int unsigned lim;
      lim = 1 << eff_bits();
      if (cfg_colors != 0 && cfg_colors < lim) lim = cfg_colors;
      if (lim > PAL_DEPTH) lim = PAL_DEPTH;
      return lim;
   endfunction

   function automatic req_payload_type palette_item(input logic [7:0] slot,
                                                    input logic [COLOR_W-1:0] colour);
      req_payload_type r;
      r.req_type      = REQ_PALETTE;
      r.palette_slot  = slot;
      r.palette_color = colour;
      r.data_byte     = 8'($urandom);
      return r;
   endfunction

   function automatic req_payload_type data_item(input logic [7:0] value);
      req_payload_type r;
      r.req_type      = REQ_DATA;
      r.palette_slot  = 8'($urandom);
      r.palette_color = COLOR_W'($urandom);
      r.data_byte     = value;
      return r;
   endfunction

   // Works out the pixels that one accepted transaction yields.
   task automatic predict_pixels(input req_payload_type item);
      int unsigned     bits, w, h, lim, shift, idx, ox, y, k;
      rsp_payload_type r;
      bit              row_end;
      if (item.req_type == REQ_PALETTE) begin
         if (item.palette_slot < PAL_DEPTH) begin
            pal_mem[item.palette_slot]   = item.palette_color;
            pal_valid[item.palette_slot] = 1'b1;
         end
         return;
      end
      if (stuck) return;
      bits = eff_bits();
      w    = clamp_dim(cfg_width);
      h    = clamp_dim(cfg_height);
      lim  = pal_limit();
      // Counts left beyond a narrowed image move on to the next row or image.
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      for (k = 0; k < 8 / bits; k++) begin
         shift = 8 - bits - k * bits;
         idx   = (item.data_byte >> shift) & ((1 << bits) - 1);
         ox    = cfg_mirror ? w - 1 - col_cnt : col_cnt;
         y     = cfg_top_down ? row_cnt : h - 1 - row_cnt;
         r.pixel_offset = OFFS_W'(y * w + ox);
         if (idx >= lim) begin
            r.rgba         = '0;
            r.status       = STATUS_RANGE;
            r.last_of_byte = 1'b1;
            r.image_done   = 1'b0;
            expected_pixels.push_back(r);
            stuck = 1'b1;
            return;
         end
         r.rgba       = {pal_mem[idx], ALPHA_OPAQUE};
         r.status     = STATUS_OK;
         r.image_done = 1'b0;
         col_cnt++;
         row_end = (col_cnt >= w);
         if (row_end) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
               row_cnt      = 0;
               r.image_done = 1'b1;
            end
         end
         r.last_of_byte = row_end || (k + 1 == 8 / bits);
         expected_pixels.push_back(r);
         if (row_end) break;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Entered and left on a falling edge; valid stays up for a following transaction.
   task automatic send_item(input req_payload_type item);
      while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predict_pixels(item);
      @(negedge clock);
   endtask

   // A data byte whose consumed indices are in range and already loaded;
   // the bits after a row end are left random.
   task automatic send_data_byte();
      int unsigned bits, w, col, used, lim, k, idx, shift;
      logic [7:0]  packed_byte;
      bits = eff_bits();
      w    = clamp_dim(cfg_width);
      lim  = pal_limit();
      col  = (col_cnt >= w) ? 0 : col_cnt;
      used = w - col;
      if (used > 8 / bits) used = 8 / bits;
      packed_byte = 8'($urandom);
      for (k = 0; k < used; k++) begin
         idx   = $urandom_range(lim - 1);
         shift = 8 - bits - k * bits;
         if (!pal_valid[idx]) send_item(palette_item(8'(idx), COLOR_W'($urandom)));
         packed_byte &= ~8'(((1 << bits) - 1) << shift);
         packed_byte |= 8'(idx << shift);
      end
      send_item(data_item(packed_byte));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_BPP:      cfg_bpp      = value[3:0];
         CSR_WIDTH:    cfg_width    = value[DIM_W-1:0];
         CSR_HEIGHT:   cfg_height   = value[DIM_W-1:0];
         CSR_COLORS:   cfg_colors   = value[LIMIT_W-1:0];
         CSR_MIRROR_X: cfg_mirror   = value[0];
         CSR_TOP_DOWN: cfg_top_down = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] bpp, input logic [CSR_DATA_W-1:0] w,
                             input logic [CSR_DATA_W-1:0] h, input logic [CSR_DATA_W-1:0] colours,
                             input logic [CSR_DATA_W-1:0] mx, input logic [CSR_DATA_W-1:0] td);
      wait_idle();
      write_reg(CSR_BPP, bpp);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_COLORS, colours);
      write_reg(CSR_MIRROR_X, mx);
      write_reg(CSR_TOP_DOWN, td);
   endtask

   task automatic send_data_bytes(input int n);
      repeat (n) send_data_byte();
   endtask

   task automatic test_reset_defaults();
      send_item(palette_item(8'h00, 24'h000000));
      send_item(palette_item(8'hFF, 24'hFFFFFF));
      send_item(palette_item(8'hAA, COLOR_W'($urandom)));
      send_item(data_item(8'h00));
      send_item(data_item(8'hFF));
      send_item(data_item(8'hAA));
   endtask

   task automatic test_index_widths();
      set_config(1, 5, 2, 0, 1, 0);
      send_data_bytes(3);
      set_config(2, 5, 2, 0, 0, 1);
      send_data_bytes(3);
      set_config(4, 5, 2, 0, 1, 1);
      send_data_bytes(3);
   endtask

   // The tail of a row's last byte is ignored, even where it would be out of range.
   task automatic test_unused_tail_bits();
      set_config(1, 3, 2, 1, 0, 0);
      send_item(data_item(8'b000_11111));
      set_config(4, 1, 1, 5, 0, 1);
      send_item(palette_item(8'h04, COLOR_W'($urandom)));
      send_item(data_item(8'h4F));
   endtask

   task automatic test_dimension_extremes();
      set_config(8, 8191, 4096, 0, 1, 0);
      send_data_bytes(2);
      set_config(8, 0, 0, 0, 0, 1);
      send_data_bytes(2);
      set_config(8, 1, 4096, 0, 0, 0);
      send_data_bytes(2);
   endtask

   task automatic test_unsupported_widths();
      set_config(0, 2, 2, 0, 0, 0);
      send_data_byte();
      set_config(3, 2, 2, 0, 0, 0);
      send_data_byte();
      set_config(15, 2, 2, 0, 0, 0);
      send_data_byte();
   endtask

   task automatic test_palette_limits();
      set_config(8, 2, 2, 511, 0, 0);
      send_item(data_item(8'hFF));
      set_config(8, 2, 2, 1, 0, 0);
      send_data_byte();
      set_config(2, 4, 1, 2, 1, 0);
      send_data_bytes(2);
   endtask

   task automatic test_reconfig_mid_image();
      set_config(2, 6, 3, 0, 0, 0);
      send_data_bytes(3);
      wait_idle();
      write_reg(CSR_WIDTH, 3);
      send_data_bytes(2);
      wait_idle();
      write_reg(CSR_HEIGHT, 1);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      send_data_bytes(2);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_dim();
      case ($urandom_range(19))
         0: return '0;
         1: return 13'd4096;
         2: return '1;
         3: return 13'd4095;
         default: return CSR_DATA_W'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic test_random_images();
      logic [CSR_DATA_W-1:0] bpp, colours;
      int                    phase;
      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(9))
            0, 1:    bpp = 1;
            2, 3:    bpp = 2;
            4, 5:    bpp = 4;
            6, 7:    bpp = 8;
            default: bpp = CSR_DATA_W'($urandom_range(8191));
         endcase
         case ($urandom_range(3))
            0:       colours = 0;
            1:       colours = CSR_DATA_W'($urandom_range(1, 4));
            2:       colours = CSR_DATA_W'($urandom_range(511));
            default: colours = CSR_DATA_W'($urandom_range(8191));
         endcase
         set_config(bpp, random_dim(), random_dim(), colours,
                    CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
         // One phase runs flat out on both sides.
         tx_idle_on = (phase != 2);
         rx_idle_on = (phase != 2);
         repeat ((phase == 2) ? 20 : 8) begin
            if ($urandom_range(99) < 15)
               send_item(palette_item(8'($urandom_range(255)), COLOR_W'($urandom)));
            else
               send_data_byte();
         end
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_output_stall();
      set_config(1, 64, 4, 0, 0, 1);
      tx_idle_on = 1'b0;
      @(posedge clock);
      hold_go = 1'b1;
      @(negedge clock);
      send_data_bytes(24);
      tx_idle_on = 1'b1;
   endtask

   // After an out-of-range index every data byte is dropped, palette writes still load.
   task automatic test_range_error();
      set_config(2, 4, 2, 3, 0, 1);
      send_item(palette_item(8'h00, COLOR_W'($urandom)));
      send_item(palette_item(8'h01, COLOR_W'($urandom)));
      send_item(data_item({2'd1, 2'd3, 2'd2, 2'd0}));
      send_item(data_item(8'h00));
      send_item(palette_item(8'($urandom), COLOR_W'($urandom)));
      send_item(data_item(8'($urandom)));
      send_item(data_item(8'h55));
   endtask

   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transaction, pixel_offset",
                            32'(rsp_payload.pixel_offset), '0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.pixel_offset !== want.pixel_offset)
               report_mismatch("pixel_offset", 32'(rsp_payload.pixel_offset),
                               32'(want.pixel_offset));
            if (rsp_payload.rgba !== want.rgba)
               report_mismatch("rgba", rsp_payload.rgba, want.rgba);
            if (rsp_payload.status !== want.status)
               report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
            if (rsp_payload.last_of_byte !== want.last_of_byte)
               report_mismatch("last_of_byte", 32'(rsp_payload.last_of_byte),
                               32'(want.last_of_byte));
            if (rsp_payload.image_done !== want.image_done)
               report_mismatch("image_done", 32'(rsp_payload.image_done),
                               32'(want.image_done));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      tx_idle_on     = 1'b1;
      rx_idle_on     = 1'b1;
      hold_go        = 1'b0;
      mismatch_count = 0;
      col_cnt        = 0;
      row_cnt        = 0;
      stuck          = 1'b0;
      cfg_bpp        = 4'd8;
      cfg_width      = 1;
      cfg_height     = 1;
      cfg_colors     = '0;
      cfg_mirror     = 1'b0;
      cfg_top_down   = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_index_widths();
      test_unused_tail_bits();
      test_dimension_extremes();
      test_unsupported_widths();
      test_palette_limits();
      test_reconfig_mid_image();
      test_random_images();
      test_output_stall();
      test_range_error();
      wait_idle();

      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("[paletted_pixel_unpacker] OK");
      else
         $display("[paletted_pixel_unpacker] ERROR");
      $finish;
   end

endmodule
